FILE: rtl/assert_macros.svh
// assertion macros shared by the rtl modules
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled in reset
`define ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, disabled in reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: rtl/brtc_pkg.sv
// shared constants and transaction types of the block range table checker
// no dependencies
`default_nettype none

package brtc_pkg;

    localparam int TABLE_ENTRIES = 16;
    localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int DATA_W = 32;
    localparam int BB_W = 17;
    localparam int ADDR_W = 3;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_NO_MEDIA  = 3'd1;
    localparam logic [2:0] ST_ALIGN     = 3'd2;
    localparam logic [2:0] ST_NOT_FOUND = 3'd3;
    localparam logic [2:0] ST_BOUNDS    = 3'd4;
    localparam logic [2:0] ST_RESERVED  = 3'd5;
    localparam logic [2:0] ST_FULL      = 3'd6;

    localparam logic [2:0] K_CREATE   = 3'd0;
    localparam logic [2:0] K_DELETE   = 3'd1;
    localparam logic [2:0] K_READ     = 3'd2;
    localparam logic [2:0] K_WRITE    = 3'd3;
    localparam logic [2:0] K_ERASE    = 3'd4;
    localparam logic [2:0] K_VALIDATE = 3'd5;

    localparam logic REG_MEDIA  = 1'b0;
    localparam logic REG_BBYTES = 1'b1;

    typedef struct packed {
        logic [2:0]        kind;
        logic [DATA_W-1:0] owner;
        logic [DATA_W-1:0] range_id;
        logic [DATA_W-1:0] offset;
        logic [DATA_W-1:0] count;
        logic              make_private;
        logic [DATA_W-1:0] mem_addr;
    } t_req;

    typedef struct packed {
        logic [2:0]        status;
        logic              ok;
        logic [DATA_W-1:0] new_range_id;
        logic [DATA_W-1:0] xfer_start_block;
        logic [DATA_W-1:0] xfer_block_count;
        logic [DATA_W-1:0] target_addr;
    } t_rsp;

endpackage

`default_nettype wire

FILE: rtl/brtc_div.sv
// iterative restoring divider, one quotient bit per cycle
// depends on brtc_pkg and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module brtc_div
    import brtc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire logic [DATA_W-1:0] i_dividend,
    input  wire logic [BB_W-1:0]   i_divisor,
    output logic                   o_done,
    output logic [DATA_W-1:0]      o_quot,
    output logic [BB_W-1:0]        o_rem
);

    localparam int CNT_W = $clog2(DATA_W);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DATA_W-1:0] r_quo;
    logic [BB_W-1:0]   r_rem;
    logic [BB_W-1:0]   r_dvs;

    logic [BB_W:0]     w_sh;
    logic              w_ge;
    logic [BB_W:0]     w_diff;
    logic [BB_W-1:0]   n_rem;
    logic [DATA_W-1:0] n_quo;

    always_comb begin
        w_sh   = {r_rem, r_quo[DATA_W-1]};
        w_ge   = w_sh >= {1'b0, r_dvs};
        w_diff = w_sh - {1'b0, r_dvs};
        n_rem  = w_ge ? w_diff[BB_W-1:0] : w_sh[BB_W-1:0];
        n_quo  = {r_quo[DATA_W-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(DATA_W - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_quo <= n_quo;
            r_rem <= n_rem;
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quo;
    assign o_rem  = r_rem;

    `ASSERT_IMP(a_rem_below_divisor, i_clk, i_rst_n, r_done && (r_dvs != '0), r_rem < r_dvs)
    `ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, i_start, r_busy && !r_done)

endmodule

`default_nettype wire

FILE: rtl/block_range_table_checker_core.sv
// Block range table checker: one request at a time. A request is taken when the block is
// idle; a create or delete that passes its first checks scans all TABLE_ENTRIES entries, a
// transfer uses the shared 32-step divider (offset, count, address and translated start)
// plus the table scan and a shared multiplier; a validate skips the translated start division.
// The result is held in an output register until taken; no new request enters meanwhile.
// depends on brtc_pkg, brtc_div and assert_macros.svh
`default_nettype none
`include "assert_macros.svh"

module block_range_table_checker_core
    import brtc_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    output logic                   o_req_stall,
    input  wire t_req              i_req,
    output logic                   o_rsp_valid,
    input  wire logic              i_rsp_stall,
    output t_rsp                   o_rsp,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [ADDR_W-1:0] paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    typedef enum logic [10:0] {
        S_IDLE     = 11'b00000000001,
        S_DIV_OFF  = 11'b00000000010,
        S_DIV_CNT  = 11'b00000000100,
        S_DIV_ADDR = 11'b00000001000,
        S_SCAN     = 11'b00000010000,
        S_EVAL     = 11'b00000100000,
        S_MUL_RB   = 11'b00001000000,
        S_CHECK    = 11'b00010000000,
        S_MUL_ST   = 11'b00100000000,
        S_DIV_BST  = 11'b01000000000,
        S_OUT      = 11'b10000000000
    } t_state;

    t_state r_state;

    logic [DATA_W-1:0] r_media;
    logic [BB_W-1:0]   r_bb;
    logic [DATA_W-1:0] r_last_id;

    logic [TABLE_ENTRIES-1:0] r_valid;
    logic [DATA_W-1:0]        r_ent_id    [TABLE_ENTRIES];
    logic [DATA_W-1:0]        r_ent_owner [TABLE_ENTRIES];
    logic [DATA_W-1:0]        r_ent_start [TABLE_ENTRIES];
    logic [DATA_W-1:0]        r_ent_blk   [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] r_ent_priv;

    t_req              r_req;
    t_rsp              r_rsp;
    logic [IDX_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_slot;
    logic              r_found;
    logic              r_ovl;
    logic [DATA_W-1:0] r_estart;
    logic [DATA_W-1:0] r_eblk;
    logic [DATA_W-1:0] r_prod;
    logic [DATA_W-1:0] r_qcnt;
    logic              r_off_nz;
    logic              r_cnt_nz;
    logic              r_addr_nz;
    logic              r_div_start;

    logic                   w_accept;
    logic                   w_cfg_wr;
    logic                   w_div_done;
    logic [DATA_W-1:0]      w_div_quot;
    logic [BB_W-1:0]        w_div_rem;
    logic [DATA_W-1:0]      w_div_in;
    logic [DATA_W+BB_W-1:0] w_mul;
    logic [DATA_W-1:0]      w_mul_op;
    logic                   w_ent_valid;
    logic                   w_match_id;
    logic                   w_cond;
    logic                   w_over;
    logic                   w_rb_bad;
    logic                   w_create_bad;
    logic                   w_scan_last;

    assign w_accept    = i_req_valid && !o_req_stall;
    assign o_req_stall = r_state != S_IDLE;
    assign o_rsp_valid = r_state == S_OUT;
    assign o_rsp       = r_rsp;
    assign pready      = 1'b1;
    assign w_cfg_wr    = psel && penable && pwrite;
    assign prdata      = (paddr[2] == REG_BBYTES) ? {{(32-BB_W){1'b0}}, r_bb} : r_media;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_media <= '0;
            r_bb    <= '0;
        end else if (w_cfg_wr) begin
            if (paddr[2] == REG_BBYTES) begin
                r_bb <= pwdata[BB_W-1:0];
            end else begin
                r_media <= pwdata;
            end
        end
    end

    always_comb begin
        case (r_state)
            S_DIV_OFF:  w_div_in = r_req.offset;
            S_DIV_CNT:  w_div_in = r_req.count;
            S_DIV_ADDR: w_div_in = r_req.mem_addr;
            default:    w_div_in = r_prod;
        endcase
    end

    brtc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_div_start),
        .i_dividend (w_div_in),
        .i_divisor  (r_bb),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    assign w_mul_op = (r_state == S_MUL_ST) ? r_estart : r_eblk;
    assign w_mul    = w_mul_op * r_bb;

    always_comb begin
        w_ent_valid = r_valid[r_idx];
        w_match_id  = w_ent_valid && (r_ent_id[r_idx] == r_req.range_id);
        case (r_req.kind)
            K_CREATE: w_cond = !w_ent_valid;
            K_DELETE: w_cond = w_match_id && (r_ent_owner[r_idx] == r_req.owner);
            default:  w_cond = w_match_id;
        endcase
        if (r_req.offset < r_ent_start[r_idx]) begin
            w_over = (r_ent_start[r_idx] - r_req.offset) < r_req.count;
        end else begin
            w_over = (r_req.offset - r_ent_start[r_idx]) < r_ent_blk[r_idx];
        end
        w_rb_bad     = (r_req.offset >= r_prod) || ((r_prod - r_req.offset) < r_req.count);
        w_create_bad = (i_req.offset >= r_media) || ((r_media - i_req.offset) < i_req.count);
        w_scan_last  = r_idx == IDX_W'(TABLE_ENTRIES - 1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_last_id   <= '0;
            r_div_start <= 1'b0;
        end else begin
            r_div_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        if (i_req.kind == K_VALIDATE) begin
                            if (r_media == '0 || r_bb == '0 || i_req.count == '0) begin
                                r_state <= S_OUT;
                            end else begin
                                r_state     <= S_DIV_OFF;
                                r_div_start <= 1'b1;
                            end
                        end else if (i_req.kind > K_VALIDATE) begin
                            r_state <= S_OUT;
                        end else if (r_media == '0) begin
                            r_state <= S_OUT;
                        end else if (i_req.kind == K_CREATE) begin
                            r_state <= w_create_bad ? S_OUT : S_SCAN;
                        end else if (i_req.kind == K_DELETE) begin
                            r_state <= S_SCAN;
                        end else if (r_bb == '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state     <= S_DIV_OFF;
                            r_div_start <= 1'b1;
                        end
                    end
                end
                S_DIV_OFF: begin
                    if (w_div_done) begin
                        r_state     <= S_DIV_CNT;
                        r_div_start <= 1'b1;
                    end
                end
                S_DIV_CNT: begin
                    if (w_div_done) begin
                        r_state     <= S_DIV_ADDR;
                        r_div_start <= 1'b1;
                    end
                end
                S_DIV_ADDR: begin
                    if (w_div_done) begin
                        if (r_off_nz || r_cnt_nz) begin
                            r_state <= S_OUT;
                        end else if (r_req.kind == K_VALIDATE && w_div_rem != '0) begin
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    if (w_scan_last) begin
                        r_state <= S_EVAL;
                    end
                end
                S_EVAL: begin
                    if (r_req.kind == K_CREATE) begin
                        r_state <= S_OUT;
                        if (r_found) begin
                            r_last_id <= r_last_id + 1'b1;
                            if (!r_ovl) begin
                                r_valid[r_slot] <= 1'b1;
                            end
                        end
                    end else if (r_req.kind == K_DELETE) begin
                        r_state <= S_OUT;
                        if (r_found) begin
                            r_valid[r_slot] <= 1'b0;
                        end
                    end else begin
                        r_state <= r_found ? S_MUL_RB : S_OUT;
                    end
                end
                S_MUL_RB: r_state <= S_CHECK;
                S_CHECK: begin
                    if (r_req.kind == K_VALIDATE || w_rb_bad) begin
                        r_state <= S_OUT;
                    end else if (r_req.kind != K_ERASE && r_addr_nz) begin
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_MUL_ST;
                    end
                end
                S_MUL_ST: begin
                    r_state     <= S_DIV_BST;
                    r_div_start <= 1'b1;
                end
                S_DIV_BST: begin
                    if (w_div_done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!i_rsp_stall) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_req   <= i_req;
                r_rsp   <= '0;
                r_idx   <= '0;
                r_slot  <= '0;
                r_found <= 1'b0;
                r_ovl   <= 1'b0;
                if (i_req.kind < K_VALIDATE) begin
                    if (r_media == '0) begin
                        r_rsp.status <= ST_NO_MEDIA;
                    end else if (i_req.kind == K_CREATE) begin
                        if (w_create_bad) begin
                            r_rsp.status <= ST_BOUNDS;
                        end
                    end else if (i_req.kind != K_DELETE && r_bb == '0) begin
                        r_rsp.status <= ST_ALIGN;
                    end
                end
            end
            S_DIV_OFF: begin
                if (w_div_done) begin
                    r_off_nz <= w_div_rem != '0;
                end
            end
            S_DIV_CNT: begin
                if (w_div_done) begin
                    r_cnt_nz <= w_div_rem != '0;
                    r_qcnt   <= w_div_quot;
                end
            end
            S_DIV_ADDR: begin
                if (w_div_done) begin
                    r_addr_nz <= w_div_rem != '0;
                    if ((r_off_nz || r_cnt_nz) && r_req.kind != K_VALIDATE) begin
                        r_rsp.status <= ST_ALIGN;
                    end
                end
            end
            S_SCAN: begin
                r_idx <= r_idx + 1'b1;
                if (!r_found && w_cond) begin
                    r_found  <= 1'b1;
                    r_slot   <= r_idx;
                    r_estart <= r_ent_start[r_idx];
                    r_eblk   <= r_ent_blk[r_idx];
                end
                if (w_ent_valid && w_over && (r_req.make_private || r_ent_priv[r_idx])) begin
                    r_ovl <= 1'b1;
                end
            end
            S_EVAL: begin
                if (r_req.kind == K_CREATE) begin
                    if (!r_found) begin
                        r_rsp.status <= ST_FULL;
                    end else if (r_ovl) begin
                        r_rsp.status <= ST_RESERVED;
                    end else begin
                        r_rsp.ok                   <= 1'b1;
                        r_rsp.new_range_id         <= r_last_id + 1'b1;
                        r_ent_id[r_slot]           <= r_last_id + 1'b1;
                        r_ent_owner[r_slot]        <= r_req.owner;
                        r_ent_start[r_slot]        <= r_req.offset;
                        r_ent_blk[r_slot]          <= r_req.count;
                        r_ent_priv[r_slot]         <= r_req.make_private;
                    end
                end else if (!r_found) begin
                    if (r_req.kind != K_VALIDATE) begin
                        r_rsp.status <= ST_NOT_FOUND;
                    end
                end else if (r_req.kind == K_DELETE) begin
                    r_rsp.ok <= 1'b1;
                end
            end
            S_MUL_RB: r_prod <= w_mul[DATA_W-1:0];
            S_CHECK: begin
                if (r_req.kind == K_VALIDATE) begin
                    r_rsp.ok <= !w_rb_bad;
                end else if (w_rb_bad) begin
                    r_rsp.status <= ST_BOUNDS;
                end else if (r_req.kind != K_ERASE && r_addr_nz) begin
                    r_rsp.status <= ST_ALIGN;
                end
            end
            S_MUL_ST: r_prod <= r_req.offset + w_mul[DATA_W-1:0];
            S_DIV_BST: begin
                if (w_div_done) begin
                    r_rsp.ok               <= 1'b1;
                    r_rsp.xfer_start_block <= w_div_quot;
                    r_rsp.xfer_block_count <= r_qcnt;
                    r_rsp.target_addr      <= (r_req.kind == K_ERASE) ? '0 : r_req.mem_addr;
                end
            end
            default: ;
        endcase
    end

    `ASSERT_NEXT(a_accept_blocks, i_clk, i_rst_n, w_accept, o_req_stall)
    `ASSERT_IMP(a_lastid_create, i_clk, i_rst_n, $past(i_rst_n) && !$stable(r_last_id), $past(r_state) == S_EVAL && r_req.kind == K_CREATE)
    `ASSERT_IMP(a_newid_ok, i_clk, i_rst_n, o_rsp_valid && (o_rsp.new_range_id != '0), o_rsp.ok && r_req.kind == K_CREATE)
    `ASSERT_IMP(a_xfer_ok, i_clk, i_rst_n, o_rsp_valid && (o_rsp.target_addr != '0), o_rsp.ok && (r_req.kind == K_READ || r_req.kind == K_WRITE))

endmodule

`default_nettype wire

FILE: tb/tb_block_range_table_checker_core.sv
// testbench for block_range_table_checker_core: random and directed requests against a
// behavioral model of the range table, responses compared field by field
// depends on brtc_pkg and the core rtl
`default_nettype none

module tb_block_range_table_checker_core;
    import brtc_pkg::*;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_req_valid;
    logic              o_req_stall;
    t_req              i_req;
    logic              o_rsp_valid;
    logic              i_rsp_stall;
    t_rsp              o_rsp;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [31:0]       pwdata;
    logic [31:0]       prdata;
    logic              pready;

    block_range_table_checker_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_req_valid(i_req_valid), .o_req_stall(o_req_stall), .i_req(i_req),
        .o_rsp_valid(o_rsp_valid), .i_rsp_stall(i_rsp_stall), .o_rsp(o_rsp),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // model state
    logic [31:0] mdl_media;
    logic [31:0] mdl_bbytes;
    logic        tbl_valid [TABLE_ENTRIES];
    logic [31:0] tbl_id    [TABLE_ENTRIES];
    logic [31:0] tbl_owner [TABLE_ENTRIES];
    logic [31:0] tbl_start [TABLE_ENTRIES];
    logic [31:0] tbl_blocks[TABLE_ENTRIES];
    logic        tbl_priv  [TABLE_ENTRIES];
    logic [31:0] last_id;

    t_req pending_reqs[$];
    t_rsp expected_rsps[$];
    int   errors;
    int   n_sent;
    int   n_checked;
    bit   quiet;
    int   req_gap;
    int   rsp_gap;
    int   n_ok;

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    function automatic int find_range(input logic [31:0] id);
        for (int k = 0; k < TABLE_ENTRIES; k++)
            if (tbl_valid[k] && tbl_id[k] == id) return k;
        return -1;
    endfunction

    function automatic t_rsp predict_table(input t_req r);
        t_rsp        p;
        int          slot;
        int          k;
        logic        hit;
        logic        over;
        logic [31:0] rb;
        logic [31:0] bb;
        p = '0;
        bb = mdl_bbytes;
        slot = -1;
        hit = 1'b0;
        if (r.kind == K_VALIDATE) begin
            if (mdl_media != 0 && bb != 0 && r.count != 0 && r.mem_addr % bb == 0 &&
                r.offset % bb == 0 && r.count % bb == 0) begin
                k = find_range(r.range_id);
                if (k >= 0) begin
                    rb = tbl_blocks[k] * bb;
                    if (r.offset < rb && (rb - r.offset) >= r.count) p.ok = 1'b1;
                end
            end
            return p;
        end
        if (r.kind > K_VALIDATE) return p;
        p.status = ST_OK;
        if (mdl_media == 0) begin
            p.status = ST_NO_MEDIA;
        end else if (r.kind == K_CREATE) begin
            if (r.offset >= mdl_media || (mdl_media - r.offset) < r.count) begin
                p.status = ST_BOUNDS;
            end else begin
                for (k = 0; k < TABLE_ENTRIES; k++)
                    if (!tbl_valid[k] && slot < 0) slot = k;
                if (slot < 0) begin
                    p.status = ST_FULL;
                end else begin
                    last_id = last_id + 1;
                    for (k = 0; k < TABLE_ENTRIES; k++) begin
                        if (tbl_valid[k]) begin
                            if (r.offset < tbl_start[k])
                                over = (tbl_start[k] - r.offset) < r.count;
                            else
                                over = (r.offset - tbl_start[k]) < tbl_blocks[k];
                            if (over && (r.make_private || tbl_priv[k])) hit = 1'b1;
                        end
                    end
                    if (hit) begin
                        p.status = ST_RESERVED;
                    end else begin
                        tbl_valid[slot] = 1'b1;
                        tbl_id[slot] = last_id;
                        tbl_owner[slot] = r.owner;
                        tbl_start[slot] = r.offset;
                        tbl_blocks[slot] = r.count;
                        tbl_priv[slot] = r.make_private;
                        p.new_range_id = last_id;
                    end
                end
            end
        end else if (r.kind == K_DELETE) begin
            p.status = ST_NOT_FOUND;
            for (k = 0; k < TABLE_ENTRIES; k++) begin
                if (p.status == ST_NOT_FOUND && tbl_valid[k] && tbl_owner[k] == r.owner &&
                    tbl_id[k] == r.range_id) begin
                    tbl_valid[k] = 1'b0;
                    p.status = ST_OK;
                end
            end
        end else if (bb == 0 || r.offset % bb != 0 || r.count % bb != 0) begin
            p.status = ST_ALIGN;
        end else begin
            k = find_range(r.range_id);
            if (k < 0) begin
                p.status = ST_NOT_FOUND;
            end else begin
                rb = tbl_blocks[k] * bb;
                if (r.offset >= rb || (rb - r.offset) < r.count) begin
                    p.status = ST_BOUNDS;
                end else if (r.kind != K_ERASE && r.mem_addr % bb != 0) begin
                    p.status = ST_ALIGN;
                end else begin
                    p.xfer_start_block = (r.offset + tbl_start[k] * bb) / bb;
                    p.xfer_block_count = r.count / bb;
                    p.target_addr = (r.kind == K_ERASE) ? 32'd0 : r.mem_addr;
                end
            end
        end
        p.ok = (p.status == ST_OK);
        return p;
    endfunction

    // request driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_req_valid <= 1'b0;
            req_gap <= 0;
        end else if (!i_req_valid || !o_req_stall) begin
            if (i_req_valid) begin
                expected_rsps.push_back(predict_table(i_req));
                n_sent <= n_sent + 1;
            end
            if (req_gap > 0) begin
                req_gap <= req_gap - 1;
                i_req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                i_req <= pending_reqs.pop_front();
                i_req_valid <= 1'b1;
                if (!quiet && $urandom_range(0, 5) == 0) req_gap <= $urandom_range(1, 9);
            end else begin
                i_req_valid <= 1'b0;
            end
        end
    end

    // response monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_rsp_stall <= 1'b0;
            rsp_gap <= 0;
        end else begin
            if (o_rsp_valid && !i_rsp_stall) begin
                if (expected_rsps.size() == 0) begin
                    $display("%0t: unexpected response %p", $time, o_rsp);
                    errors <= errors + 1;
                end else begin
                    t_rsp e;
                    e = expected_rsps.pop_front();
                    n_checked <= n_checked + 1;
                    if (e.ok) n_ok <= n_ok + 1;
                    if (e.status !== o_rsp.status || e.ok !== o_rsp.ok ||
                        e.new_range_id !== o_rsp.new_range_id ||
                        e.xfer_start_block !== o_rsp.xfer_start_block ||
                        e.xfer_block_count !== o_rsp.xfer_block_count ||
                        e.target_addr !== o_rsp.target_addr) begin
                        $display("%0t: mismatch expected %p actual %p", $time, e, o_rsp);
                        errors <= errors + 1;
                    end
                end
            end
            if (rsp_gap > 0) begin
                rsp_gap <= rsp_gap - 1;
                i_rsp_stall <= 1'b1;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                rsp_gap <= $urandom_range(0, 8);
                i_rsp_stall <= 1'b1;
            end else begin
                i_rsp_stall <= 1'b0;
            end
        end
    end

    task automatic apb_write(input logic [ADDR_W-1:0] a, input logic [31:0] d);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= a;
        pwdata <= d;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (a == 4 * REG_MEDIA) mdl_media = d;
        else mdl_bbytes = d & 32'h1FFFF;
    endtask

    task automatic set_media(input logic [31:0] blocks, input logic [31:0] bsize);
        apb_write(ADDR_W'(4 * REG_MEDIA), blocks);
        apb_write(ADDR_W'(4 * REG_BBYTES), bsize);
    endtask

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || i_req_valid || expected_rsps.size() > 0)
            @(posedge i_clk);
        repeat (200) @(posedge i_clk);
    endtask

    function automatic t_req make_req(input logic [2:0] kind, input logic [31:0] own,
                                      input logic [31:0] id, input logic [31:0] off,
                                      input logic [31:0] cnt, input logic priv,
                                      input logic [31:0] addr);
        t_req r;
        r.kind = kind;
        r.owner = own;
        r.range_id = id;
        r.offset = off;
        r.count = cnt;
        r.make_private = priv;
        r.mem_addr = addr;
        return r;
    endfunction

    // mostly well-formed requests aimed at live ranges
    function automatic t_req rand_req(input logic [31:0] bsize, input logic [31:0] blocks);
        t_req        r;
        logic [31:0] bs;
        int          sel;
        bs = (bsize == 0) ? 32'd1 : bsize;
        r = make_req(3'($urandom_range(0, 5)), $urandom_range(0, 3),
                     last_id - $urandom_range(0, 20), 0, 0, 1'($urandom_range(0, 1)),
                     bs * $urandom_range(0, 4096));
        sel = $urandom_range(0, 9);
        if (r.kind == K_CREATE) begin
            r.offset = (blocks == 0) ? $urandom : $urandom_range(0, blocks - 1);
            r.count = $urandom_range(1, 64);
            if (sel == 0) r.offset = $urandom;
            if (sel == 1) r.count = $urandom;
            if (sel == 2) r.count = 0;
        end else begin
            r.offset = bs * $urandom_range(0, 8);
            r.count = bs * $urandom_range(0, 8);
            if (sel == 0) r.offset = $urandom;
            if (sel == 1) r.count = $urandom;
            if (sel == 2) r.mem_addr = $urandom;
            if (sel == 3) r.range_id = $urandom;
        end
        if (sel == 4) r.owner = $urandom;
        if (sel == 5 && $urandom_range(0, 3) == 0) r.kind = 3'($urandom_range(6, 7));
        return r;
    endfunction

    task automatic random_phase(input int n, input logic [31:0] blocks, input logic [31:0] bs);
        repeat (n) pending_reqs.push_back(rand_req(bs, blocks));
        wait_drained();
    endtask

    initial begin
        errors = 0;
        n_sent = 0;
        n_checked = 0;
        n_ok = 0;
        quiet = 1'b0;
        mdl_media = 0;
        mdl_bbytes = 0;
        last_id = 0;
        for (int k = 0; k < TABLE_ENTRIES; k++) tbl_valid[k] = 1'b0;
        i_rst_n = 1'b0;
        i_req_valid = 1'b0;
        i_req = '0;
        i_rsp_stall = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // no media
        for (int k = 0; k < 8; k++)
            pending_reqs.push_back(make_req(3'(k), 0, 1, 0, 1, 1'b0, 0));
        wait_drained();

        // media present but zero block size
        set_media(32'd1000, 32'd0);
        pending_reqs.push_back(make_req(K_CREATE, 7, 0, 10, 20, 1'b1, 0));
        pending_reqs.push_back(make_req(K_READ, 7, 1, 0, 0, 1'b0, 0));
        pending_reqs.push_back(make_req(K_VALIDATE, 7, 1, 0, 0, 1'b0, 0));
        wait_drained();

        set_media(32'hFFFF_FFFF, 32'd65536);
        pending_reqs.push_back(make_req(K_CREATE, 1, 0, 32'hFFFF_FFFE, 1, 1'b1, 0));
        pending_reqs.push_back(make_req(K_CREATE, 1, 0, 32'hFFFF_FFFF, 1, 1'b0, 0));
        pending_reqs.push_back(make_req(K_CREATE, 1, 0, 32'hFFFF_FFF0, 32'hFFFF_FFFF, 1'b0, 0));
        pending_reqs.push_back(make_req(K_CREATE, 2, 0, 32'hFFFF_FFF0, 4, 1'b0, 0));
        pending_reqs.push_back(make_req(K_READ, 1, 1, 0, 65536, 1'b0, 65536 * 3));
        pending_reqs.push_back(make_req(K_WRITE, 1, 1, 0, 0, 1'b0, 5));
        pending_reqs.push_back(make_req(K_ERASE, 1, 1, 0, 65536, 1'b0, 5));
        pending_reqs.push_back(make_req(K_READ, 1, 1, 65536, 65536, 1'b0, 0));
        pending_reqs.push_back(make_req(K_READ, 1, 9, 0, 0, 1'b0, 0));
        pending_reqs.push_back(make_req(K_READ, 1, 1, 3, 0, 1'b0, 0));
        pending_reqs.push_back(make_req(K_VALIDATE, 1, 1, 0, 65536, 1'b0, 0));
        pending_reqs.push_back(make_req(K_VALIDATE, 1, 1, 0, 0, 1'b0, 0));
        pending_reqs.push_back(make_req(K_DELETE, 2, 1, 0, 0, 1'b0, 0));
        pending_reqs.push_back(make_req(K_DELETE, 1, 1, 0, 0, 1'b0, 0));
        for (int k = 0; k < 18; k++)
            pending_reqs.push_back(make_req(K_CREATE, 3, 0, k * 2, 1, 1'b0, 0));
        wait_drained();

        set_media(32'd1, 32'd1);
        for (int k = 0; k < TABLE_ENTRIES; k++)
            pending_reqs.push_back(make_req(K_DELETE, 3, last_id - k, 0, 0, 1'b0, 0));
        wait_drained();

        set_media(32'd4096, 32'd512);
        random_phase(400, 4096, 512);
        set_media(32'd256, 32'd3);
        random_phase(300, 256, 3);
        set_media(32'hFFFF_FFFF, 32'd65536);
        random_phase(150, 32'hFFFF_FFFF, 65536);
        set_media(32'd64, 32'd1);
        quiet = 1'b1;
        random_phase(200, 64, 1);

        $display("sent %0d requests, checked %0d responses, %0d with ok set", n_sent,
                 n_checked, n_ok);
        if (errors == 0 && expected_rsps.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("timeout with %0d responses outstanding", expected_rsps.size());
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: block_range_table_checker_core.f
+incdir+rtl
rtl/brtc_pkg.sv
rtl/brtc_div.sv
rtl/block_range_table_checker_core.sv
tb/tb_block_range_table_checker_core.sv
